/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SREC_ASSERT_SAME(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SREC_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error(msg);

`endif

/* src/srec_pkg.sv */
// ---------------------------------------------------------------------------
// srec_pkg
// Types, character codes and decode functions for the S-record parser.
// ---------------------------------------------------------------------------
`default_nettype none

package srec_pkg;

  // parse phase, one-hot
  typedef enum logic [5:0] {
    PH_LEAD   = 6'b000001,
    PH_TYPE   = 6'b000010,
    PH_CNT_HI = 6'b000100,
    PH_CNT_LO = 6'b001000,
    PH_PAY_HI = 6'b010000,
    PH_PAY_LO = 6'b100000
  } phase_t;

  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF = 8'h66;

  localparam logic [3:0] REC_S0 = 4'd0;
  localparam logic [3:0] REC_S1 = 4'd1;
  localparam logic [3:0] REC_S2 = 4'd2;
  localparam logic [3:0] REC_S3 = 4'd3;
  localparam logic [3:0] REC_S7 = 4'd7;
  localparam logic [3:0] REC_S8 = 4'd8;
  localparam logic [3:0] REC_S9 = 4'd9;

  // hex digit value, anything else reads as zero
  function automatic logic [3:0] nib_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CH_0 && c <= CH_9) begin
      t = c - CH_0;
    end else if (c >= CH_UA && c <= CH_UF) begin
      t = c - CH_UA + 8'd10;
    end else if (c >= CH_LA && c <= CH_LF) begin
      t = c - CH_LA + 8'd10;
    end
    return t[3:0];
  endfunction

  // number of address bytes for a record type
  function automatic logic [2:0] addr_bytes_of(input logic [3:0] t);
    logic [2:0] n;
    case (t)
      REC_S0, REC_S1, REC_S9: n = 3'd2;
      REC_S2, REC_S8:         n = 3'd3;
      REC_S3, REC_S7:         n = 3'd4;
      default:                n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

/* src/srec_chan_if.sv */
// ---------------------------------------------------------------------------
// srec channel interfaces
// Valid/ready channels for characters in and parsed results out.
// ---------------------------------------------------------------------------
`default_nettype none

interface srec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface srec_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  record_type;
  logic [31:0] byte_address;
  logic [7:0]  byte_index;
  logic [7:0]  byte_value;
  logic        record_end;
  logic        length_error;

  modport source (output valid, output record_type, output byte_address,
                  output byte_index, output byte_value, output record_end,
                  output length_error, input ready);
  modport sink   (input valid, input record_type, input byte_address,
                  input byte_index, input byte_value, input record_end,
                  input length_error, output ready);
endinterface

`default_nettype wire

/* src/srec_record_parser.sv */
// ---------------------------------------------------------------------------
// srec_record_parser
// Streaming S-record parser: one character per transfer in, data bytes with
// their address and a record-end result carrying the checksum out.
// ---------------------------------------------------------------------------
//  channel | dir | payload                                   | results
//  in_ch   | in  | char_in                                   | 0 or 1 per char
//  out_ch  | out | record_type, byte_address, byte_index,    |
//          |     | byte_value, record_end, length_error      |
//
//  One character per cycle sustained while the result side is ready; input
//  register, then result register. A character is decoded against the parse
//  state once the result slot is free; the 32-bit address add sets the path.
//  Synchronous active-low reset clears the parse state and both valids.
//  A stalled result holds the decode stage; the input register takes a new
//  character as soon as its contents move on.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module srec_record_parser (
  input  wire logic   clk,
  input  wire logic   rst_n,
  srec_in_if.sink     in_ch,
  srec_out_if.source  out_ch
);

  // input register
  logic       in_vld_r;
  logic [7:0] char_r;

  // parse state
  srec_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  hi_r, hi_nxt;
  logic [3:0]  type_r, type_nxt;
  logic [7:0]  byte_cnt_r, byte_cnt_nxt;
  logic [31:0] base_r, base_nxt;
  logic [7:0]  data_cnt_r, data_cnt_nxt;
  logic [7:0]  csum_r, csum_nxt;

  // result register
  logic        out_vld_r;
  logic [3:0]  res_type_r, res_type_nxt;
  logic [31:0] res_addr_r, res_addr_nxt;
  logic [7:0]  res_idx_r, res_idx_nxt;
  logic [7:0]  res_val_r, res_val_nxt;
  logic        res_end_r, res_end_nxt;
  logic        res_lerr_r, res_lerr_nxt;

  logic       fire;
  logic       emit;
  logic       is_nl;
  logic [3:0] nib;
  logic [2:0] ab;
  logic [7:0] byte_val;
  logic [8:0] k_inc;
  logic [7:0] idx;

  assign fire     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || fire;

  assign is_nl    = (char_r == srec_pkg::CH_NL);
  assign nib      = srec_pkg::nib_of(char_r);
  assign ab       = srec_pkg::addr_bytes_of(type_r);
  assign byte_val = {hi_r, nib};
  assign k_inc    = {1'b0, data_cnt_r} + 9'd1;
  assign idx      = data_cnt_r - {5'b0, ab};

  always_comb begin
    phase_nxt    = phase_r;
    hi_nxt       = hi_r;
    type_nxt     = type_r;
    byte_cnt_nxt = byte_cnt_r;
    base_nxt     = base_r;
    data_cnt_nxt = data_cnt_r;
    csum_nxt     = csum_r;
    emit         = 1'b0;
    res_type_nxt = type_r;
    res_addr_nxt = base_r;
    res_idx_nxt  = 8'd0;
    res_val_nxt  = csum_r;
    res_end_nxt  = 1'b1;
    res_lerr_nxt = (byte_cnt_r < ({5'b0, ab} + 8'd1));

    if (fire) begin
      if (is_nl) begin
        emit         = 1'b1;
        phase_nxt    = srec_pkg::PH_LEAD;
        hi_nxt       = 4'd0;
        type_nxt     = 4'd0;
        byte_cnt_nxt = 8'd0;
        base_nxt     = 32'd0;
        data_cnt_nxt = 8'd0;
        csum_nxt     = 8'd0;
      end else begin
        case (phase_r)
          srec_pkg::PH_LEAD: begin
            phase_nxt = srec_pkg::PH_TYPE;
          end
          srec_pkg::PH_TYPE: begin
            type_nxt  = nib;
            phase_nxt = srec_pkg::PH_CNT_HI;
          end
          srec_pkg::PH_CNT_HI: begin
            hi_nxt    = nib;
            phase_nxt = srec_pkg::PH_CNT_LO;
          end
          srec_pkg::PH_CNT_LO: begin
            byte_cnt_nxt = byte_val;
            phase_nxt    = srec_pkg::PH_PAY_HI;
          end
          srec_pkg::PH_PAY_HI: begin
            // bytes past the count are ignored until newline
            if (data_cnt_r < byte_cnt_r) begin
              hi_nxt    = nib;
              phase_nxt = srec_pkg::PH_PAY_LO;
            end
          end
          srec_pkg::PH_PAY_LO: begin
            phase_nxt    = srec_pkg::PH_PAY_HI;
            data_cnt_nxt = k_inc[7:0];
            if (k_inc == {1'b0, byte_cnt_r}) begin
              csum_nxt = byte_val;
            end
            if (data_cnt_r < {5'b0, ab}) begin
              base_nxt = {base_r[23:0], byte_val};
            end else if (k_inc < {1'b0, byte_cnt_r}) begin
              emit         = 1'b1;
              res_addr_nxt = base_r + {24'd0, idx};
              res_idx_nxt  = idx;
              res_val_nxt  = byte_val;
              res_end_nxt  = 1'b0;
              res_lerr_nxt = 1'b0;
            end
          end
          default: begin
            phase_nxt = srec_pkg::PH_LEAD;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      phase_r    <= srec_pkg::PH_LEAD;
      hi_r       <= 4'd0;
      type_r     <= 4'd0;
      byte_cnt_r <= 8'd0;
      base_r     <= 32'd0;
      data_cnt_r <= 8'd0;
      csum_r     <= 8'd0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (fire) begin
        out_vld_r <= emit;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      phase_r    <= phase_nxt;
      hi_r       <= hi_nxt;
      type_r     <= type_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      base_r     <= base_nxt;
      data_cnt_r <= data_cnt_nxt;
      csum_r     <= csum_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      char_r <= in_ch.char_in;
    end
    if (fire && emit) begin
      res_type_r <= res_type_nxt;
      res_addr_r <= res_addr_nxt;
      res_idx_r  <= res_idx_nxt;
      res_val_r  <= res_val_nxt;
      res_end_r  <= res_end_nxt;
      res_lerr_r <= res_lerr_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.record_type  = res_type_r;
  assign out_ch.byte_address = res_addr_r;
  assign out_ch.byte_index   = res_idx_r;
  assign out_ch.byte_value   = res_val_r;
  assign out_ch.record_end   = res_end_r;
  assign out_ch.length_error = res_lerr_r;

  // payload bytes taken never run past the count
  `SREC_ASSERT_SAME(a_cnt_bound, 1'b1, data_cnt_r <= byte_cnt_r,
                    "data counter beyond byte count")

  // a free result slot never blocks the input side
  `SREC_ASSERT_SAME(a_no_bubble, !out_vld_r || out_ch.ready, in_ch.ready,
                    "input stalled with result slot free")

  // newline returns the parser to the lead character with cleared counters
  `SREC_ASSERT_NEXT(a_nl_clear, fire && is_nl,
                    phase_r == srec_pkg::PH_LEAD && data_cnt_r == 8'd0 &&
                    byte_cnt_r == 8'd0 && out_vld_r && res_end_r,
                    "newline did not end the record")

  // a data result is never flagged as a length error
  `SREC_ASSERT_NEXT(a_data_flag, fire && emit && !is_nl,
                    out_vld_r && !res_end_r && !res_lerr_r,
                    "data result carries record-end or length error")

endmodule

`default_nettype wire

/* tb/sv/srec_record_parser_tb.sv */
// ---------------------------------------------------------------------------
// srec_record_parser_tb
// Self-checking bench for the S-record parser. Characters go in over the
// valid/ready input channel; every result transfer is compared field by
// field with a parse model or the table. A short table of hand-picked lines
// comes first, then random records (well-formed, short, bad length, noisy).
// Sender gaps and receiver stalls vary by phase, including a long stall.
// ---------------------------------------------------------------------------
module srec_record_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ITEM_TARGET = 1550;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          HOLD_CYCLES = 400;
  localparam logic [7:0]  CH_CR       = 8'h0D;
  localparam logic [7:0]  CH_S        = 8'h53;

  typedef struct packed {
    logic [3:0]  rtype;
    logic [31:0] addr;
    logic [7:0]  idx;
    logic [7:0]  value;
    logic        rec_end;
    logic        len_err;
  } parse_result_t;

  typedef struct packed {
    logic [7:0]    ch;
    logic          typed;
    parse_result_t res;
  } dir_row_t;

  localparam parse_result_t NO_RES       = '0;
  localparam parse_result_t RES_EMPTY    =
    '{srec_pkg::REC_S0, 32'd0, 8'd0, 8'd0, 1'b1, 1'b1};
  localparam parse_result_t RES_S3_DATA  =
    '{srec_pkg::REC_S3, 32'hFFFF_FFFF, 8'd0, 8'hFF, 1'b0, 1'b0};
  localparam parse_result_t RES_S3_END   =
    '{srec_pkg::REC_S3, 32'hFFFF_FFFF, 8'd0, 8'h00, 1'b1, 1'b0};
  localparam parse_result_t RES_SHORT    =
    '{srec_pkg::REC_S0, 32'h0000_0012, 8'd0, 8'h00, 1'b1, 1'b1};

  // empty line; full-range S3 line with lower case digits and a stray CR;
  // odd lead and type characters with a count too small and the line cut short
  localparam dir_row_t DIRECTED_ROWS [26] = '{
    '{srec_pkg::CH_NL, 1'b1, RES_EMPTY},
    '{"S",   1'b0, NO_RES},
    '{"3",   1'b0, NO_RES},
    '{"0",   1'b0, NO_RES},
    '{"6",   1'b0, NO_RES},
    '{"F",   1'b0, NO_RES},
    '{"F",   1'b0, NO_RES},
    '{"F",   1'b0, NO_RES},
    '{"F",   1'b0, NO_RES},
    '{"F",   1'b0, NO_RES},
    '{"F",   1'b0, NO_RES},
    '{"F",   1'b0, NO_RES},
    '{"F",   1'b0, NO_RES},
    '{"f",   1'b0, NO_RES},
    '{"f",   1'b1, RES_S3_DATA},
    '{"0",   1'b0, NO_RES},
    '{"0",   1'b0, NO_RES},
    '{CH_CR, 1'b0, NO_RES},
    '{srec_pkg::CH_NL, 1'b1, RES_S3_END},
    '{8'hFF, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{"0",   1'b0, NO_RES},
    '{"2",   1'b0, NO_RES},
    '{"1",   1'b0, NO_RES},
    '{"2",   1'b0, NO_RES},
    '{srec_pkg::CH_NL, 1'b1, RES_SHORT}
  };

  logic clk = 1'b0;
  logic rst_n;

  srec_in_if  in_ch ();
  srec_out_if out_ch ();

  srec_record_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // parse model state
  srec_pkg::phase_t line_phase = srec_pkg::PH_LEAD;
  logic [3:0]  nib_hi      = '0;
  logic [3:0]  rec_type    = '0;
  logic [7:0]  byte_cnt    = '0;
  logic [31:0] base_addr   = '0;
  logic [7:0]  bytes_taken = '0;
  logic [7:0]  csum_byte   = '0;

  parse_result_t pending_results [$];
  logic [7:0]    line_buf [$];

  int          fail_count     = 0;
  int          results_seen   = 0;
  int          items_sent     = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  logic        hold_request   = 1'b0;
  logic        out_hold       = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    if (c >= srec_pkg::CH_0 && c <= srec_pkg::CH_9) return c[3:0];
    if ((c >= srec_pkg::CH_UA && c <= srec_pkg::CH_UF) ||
        (c >= srec_pkg::CH_LA && c <= srec_pkg::CH_LF)) return c[3:0] + 4'd9;
    return 4'd0;
  endfunction

  function automatic int addr_len(input logic [3:0] t);
    case (t)
      srec_pkg::REC_S0, srec_pkg::REC_S1, srec_pkg::REC_S9: return 2;
      srec_pkg::REC_S2, srec_pkg::REC_S8:                   return 3;
      srec_pkg::REC_S3, srec_pkg::REC_S7:                   return 4;
      default:                                              return 0;
    endcase
  endfunction

  // advances the parse model by one character; returns 1 when it yields a result
  function automatic bit parse_char(input logic [7:0] c, output parse_result_t r);
    logic [3:0] nib;
    logic [7:0] v;
    int         ab;
    int         k;
    nib = hex_value(c);
    ab  = addr_len(rec_type);
    r   = NO_RES;
    if (c == srec_pkg::CH_NL) begin
      r = '{rec_type, base_addr, 8'd0, csum_byte, 1'b1, (int'(byte_cnt) < ab + 1)};
      line_phase  = srec_pkg::PH_LEAD;
      nib_hi      = '0;
      rec_type    = '0;
      byte_cnt    = '0;
      base_addr   = '0;
      bytes_taken = '0;
      csum_byte   = '0;
      return 1'b1;
    end
    case (line_phase)
      srec_pkg::PH_LEAD: line_phase = srec_pkg::PH_TYPE;
      srec_pkg::PH_TYPE: begin
        rec_type   = nib;
        line_phase = srec_pkg::PH_CNT_HI;
      end
      srec_pkg::PH_CNT_HI: begin
        nib_hi     = nib;
        line_phase = srec_pkg::PH_CNT_LO;
      end
      srec_pkg::PH_CNT_LO: begin
        byte_cnt   = {nib_hi, nib};
        line_phase = srec_pkg::PH_PAY_HI;
      end
      srec_pkg::PH_PAY_HI: begin
        // characters past the counted bytes are dropped
        if (bytes_taken < byte_cnt) begin
          nib_hi     = nib;
          line_phase = srec_pkg::PH_PAY_LO;
        end
      end
      default: begin
        k           = int'(bytes_taken);
        v           = {nib_hi, nib};
        line_phase  = srec_pkg::PH_PAY_HI;
        bytes_taken = bytes_taken + 8'd1;
        if (k + 1 == int'(byte_cnt)) csum_byte = v;
        if (k < ab) begin
          base_addr = {base_addr[23:0], v};
        end else if (k + 1 < int'(byte_cnt)) begin
          r = '{rec_type, base_addr + 32'(k - ab), 8'(k - ab), v, 1'b0, 1'b0};
          return 1'b1;
        end
      end
    endcase
    return 1'b0;
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == srec_pkg::CH_NL);
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return srec_pkg::CH_0 + 8'(n);
    return ($urandom_range(0, 1) ? srec_pkg::CH_LA : srec_pkg::CH_UA) + 8'(n) - 8'd10;
  endfunction

  // one byte as two digits, now and then a digit replaced by junk
  function automatic void add_byte_hex(input logic [7:0] b);
    line_buf.push_back(($urandom_range(0, 99) < 3) ? noise_char() : hex_char(b[7:4]));
    line_buf.push_back(($urandom_range(0, 99) < 3) ? noise_char() : hex_char(b[3:0]));
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    $display("mismatch %s: got 0x%0h want 0x%0h (result %0d)", what, got, want, results_seen);
  endtask

  task automatic check_result();
    parse_result_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing pending, byte_value",
                      32'(out_ch.byte_value), 32'd0);
    end else begin
      want = pending_results.pop_front();
      if (out_ch.record_type !== want.rtype)
        report_mismatch("record_type", 32'(out_ch.record_type), 32'(want.rtype));
      if (out_ch.byte_address !== want.addr)
        report_mismatch("byte_address", out_ch.byte_address, want.addr);
      if (out_ch.byte_index !== want.idx)
        report_mismatch("byte_index", 32'(out_ch.byte_index), 32'(want.idx));
      if (out_ch.byte_value !== want.value)
        report_mismatch("byte_value", 32'(out_ch.byte_value), 32'(want.value));
      if (out_ch.record_end !== want.rec_end)
        report_mismatch("record_end", 32'(out_ch.record_end), 32'(want.rec_end));
      if (out_ch.length_error !== want.len_err)
        report_mismatch("length_error", 32'(out_ch.length_error), 32'(want.len_err));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_result();
    out_ch.ready <= !out_hold && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // long receiver hold-off, sender keeps offering characters meanwhile
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request <= 1'b0;
        out_hold     <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_hold     <= 1'b0;
      end
    end
  end

  // offers one character until transfer, then runs it through the model
  task automatic push_char(input logic [7:0] c, input bit counted, input bit typed,
                           input parse_result_t typed_res);
    parse_result_t r;
    bit            has_res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.char_in <= c;
    do @(posedge clk); while (!in_ch.ready);
    has_res = parse_char(c, r);
    if (typed) pending_results.push_back(typed_res);
    else if (has_res) pending_results.push_back(r);
    if (counted) items_sent++;
  endtask

  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 65; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 65; end
      default: begin send_idle_pct = 12; recv_stall_pct = 12; end
    endcase
  endtask

  task automatic send_record(input bit longest);
    logic [3:0]  rtype;
    logic [31:0] addr;
    logic [7:0]  pay;
    int          ab;
    int          cnt;
    int          shape;
    int          keep;
    int          junk_at;
    line_buf.delete();
    shape = $urandom_range(0, 99);
    if (!longest && shape >= 92) begin
      // line of raw bytes
      repeat ($urandom_range(0, 10)) line_buf.push_back(noise_char());
    end else begin
      case ($urandom_range(0, 8))
        0:       rtype = srec_pkg::REC_S0;
        1:       rtype = srec_pkg::REC_S1;
        2:       rtype = srec_pkg::REC_S2;
        3:       rtype = srec_pkg::REC_S3;
        4:       rtype = srec_pkg::REC_S7;
        5:       rtype = srec_pkg::REC_S8;
        6:       rtype = srec_pkg::REC_S9;
        default: rtype = 4'($urandom_range(0, 15));
      endcase
      ab = addr_len(rtype);
      keep = $urandom_range(0, 99);
      if (longest)        cnt = 255;
      else if (keep < 70) cnt = ab + 1 + $urandom_range(0, 6);
      else if (keep < 96) cnt = ab + 1 + $urandom_range(7, 24);
      else                cnt = ab + 1 + $urandom_range(25, 254 - ab);
      if (!longest && shape < 8) cnt = $urandom_range(0, ab);
      addr = $urandom();
      if ($urandom_range(0, 9) == 0) addr = 32'hFFFF_FFFF - $urandom_range(0, 3);
      line_buf.push_back(($urandom_range(0, 9) != 0) ? CH_S : noise_char());
      line_buf.push_back(($urandom_range(0, 49) != 0) ? hex_char(rtype) : noise_char());
      add_byte_hex(8'(cnt));
      for (int i = 0; i < cnt; i++) begin
        if (i < ab) pay = 8'(addr >> (8 * (ab - 1 - i)));
        else        pay = 8'($urandom_range(0, 255));
        add_byte_hex(pay);
      end
      if (!longest && shape >= 8 && shape < 16) begin
        keep = $urandom_range(0, line_buf.size());
        while (line_buf.size() > keep) void'(line_buf.pop_back());
      end
    end
    junk_at = line_buf.size();
    if (!longest && shape >= 16 && shape < 24) begin
      repeat ($urandom_range(1, 3))
        line_buf.push_back($urandom_range(0, 1) ? CH_CR : noise_char());
    end
    line_buf.push_back(srec_pkg::CH_NL);
    foreach (line_buf[i])
      push_char(line_buf[i], (i < junk_at) || (i == line_buf.size() - 1), 1'b0, NO_RES);
  endtask

  initial begin
    int stage;
    bit paused;
    bit held;
    bit longest_done;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.char_in = 8'd0;
    out_ch.ready  = 1'b0;
    paused        = 1'b0;
    held          = 1'b0;
    longest_done  = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(0);
    foreach (DIRECTED_ROWS[i])
      push_char(DIRECTED_ROWS[i].ch, 1'b1, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
    wait_results_done();

    items_sent = 0;
    while (items_sent < ITEM_TARGET) begin
      stage = items_sent / 300;
      set_idling((stage < 4) ? stage : $urandom_range(0, 3));
      if (stage == 2 && !paused) begin
        wait_results_done();
        paused = 1'b1;
      end
      if (stage == 3 && !held) begin
        hold_request <= 1'b1;
        held = 1'b1;
      end
      if (!longest_done && items_sent >= 1200) begin
        send_record(1'b1);
        longest_done = 1'b1;
      end else begin
        send_record(1'b0);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
